// ----- hw/rtl/lsmt_pkg.sv -----
// ----------------------------------------------------------------------------
// LCD scanline mode timer package
// Shared types, register indexes, mode codes and default timing constants.
// ----------------------------------------------------------------------------
package lsmt_pkg;

    // Default timing constants (cycles and line numbers).
    localparam int DEF_LINE_CYCLES     = 456;
    localparam int DEF_OAM_CYCLES      = 80;
    localparam int DEF_TRANSFER_CYCLES = 172;
    localparam int DEF_VISIBLE_LINES   = 144;
    localparam int DEF_LAST_LINE       = 153;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_HBLANK_EN  = 3'd0;
    localparam logic [2:0] REG_VBLANK_EN  = 3'd1;
    localparam logic [2:0] REG_OAM_EN     = 3'd2;
    localparam logic [2:0] REG_LYC_EN     = 3'd3;
    localparam logic [2:0] REG_LINE_CMP   = 3'd4;

    // LCD mode codes.
    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_OAM      = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    // One tick.
    typedef struct packed {
        logic [5:0] elapsed_cycles;
        logic       lcd_on;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic [1:0] lcd_mode;
        logic [7:0] current_line;
        logic       coincidence;
        logic       stat_irq;
        logic       vblank_irq;
        logic       draw_request;
        logic [7:0] draw_line;
    } out_item_t;

    // Configuration register contents.
    typedef struct packed {
        logic       hblank_irq_enable;
        logic       vblank_mode_irq_enable;
        logic       oam_irq_enable;
        logic       lyc_irq_enable;
        logic [7:0] line_compare;
    } cfg_t;

endpackage

// ----- hw/rtl/lcd_scanline_mode_timer.sv -----
// ----------------------------------------------------------------------------
// Path: a tick accepted into the input register has its result computed by the
// timing update and held in the result register, which drives out_valid.
// Throughput: one tick per cycle; the input register, the timing update and
// the result register form a two-stage path with full handshake back-pressure.
// Reset: rst_n clears control state, config registers, line, mode and flags,
// and reloads the cycle countdown to one full line.
// ----------------------------------------------------------------------------
// LCD scanline mode timer
// Tracks LCD line timing per tick and raises STAT, vblank and draw requests.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer #(
    parameter int LINE_CYCLES     = lsmt_pkg::DEF_LINE_CYCLES,
    parameter int OAM_CYCLES      = lsmt_pkg::DEF_OAM_CYCLES,
    parameter int TRANSFER_CYCLES = lsmt_pkg::DEF_TRANSFER_CYCLES,
    parameter int VISIBLE_LINES   = lsmt_pkg::DEF_VISIBLE_LINES,
    parameter int LAST_LINE       = lsmt_pkg::DEF_LAST_LINE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  lsmt_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lsmt_pkg::out_item_t         out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsmt_pkg::ADDR_W-1:0] paddr,
    input  logic [lsmt_pkg::DATA_W-1:0] pwdata,
    output logic [lsmt_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import lsmt_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      advance;

    // Configuration registers.
    lsmt_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Timing state and per-tick update.
    lsmt_timing_core #(
        .LINE_CYCLES     (LINE_CYCLES),
        .OAM_CYCLES      (OAM_CYCLES),
        .TRANSFER_CYCLES (TRANSFER_CYCLES),
        .VISIBLE_LINES   (VISIBLE_LINES),
        .LAST_LINE       (LAST_LINE)
    ) u_timing_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // A held tick moves on when the result register is empty or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Input register: takes a transaction whenever it is empty or moving on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    // A vblank interrupt is raised only on arrival at the first blank line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.vblank_irq)
        |-> (out_item_reg.current_line == 8'(VISIBLE_LINES)))
        else $error("vblank interrupt away from first blank line");

    // A draw request only comes with the OAM search mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.draw_request)
        |-> (out_item_reg.lcd_mode == MODE_OAM))
        else $error("draw request outside OAM search");

    // A held tick that cannot move on stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held tick lost from input register");

    // The line counter never passes the last line.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.current_line <= 8'(LAST_LINE)))
        else $error("line counter beyond last line");

endmodule

// ----- hw/rtl/lsmt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// LCD scanline mode timer configuration registers
// APB-style register file holding interrupt enables and the line compare value.
// ----------------------------------------------------------------------------
module lsmt_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsmt_pkg::ADDR_W-1:0] paddr,
    input  logic [lsmt_pkg::DATA_W-1:0] pwdata,
    output logic [lsmt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lsmt_pkg::cfg_t              cfg
);
    import lsmt_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // Register writes complete in the access phase of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_HBLANK_EN: cfg_reg.hblank_irq_enable      <= pwdata[0];
                REG_VBLANK_EN: cfg_reg.vblank_mode_irq_enable <= pwdata[0];
                REG_OAM_EN:    cfg_reg.oam_irq_enable         <= pwdata[0];
                REG_LYC_EN:    cfg_reg.lyc_irq_enable         <= pwdata[0];
                REG_LINE_CMP:  cfg_reg.line_compare           <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // Read data multiplexer.
    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            REG_HBLANK_EN: prdata[0]   = cfg_reg.hblank_irq_enable;
            REG_VBLANK_EN: prdata[0]   = cfg_reg.vblank_mode_irq_enable;
            REG_OAM_EN:    prdata[0]   = cfg_reg.oam_irq_enable;
            REG_LYC_EN:    prdata[0]   = cfg_reg.lyc_irq_enable;
            REG_LINE_CMP:  prdata[7:0] = cfg_reg.line_compare;
            default:       prdata      = '0;
        endcase
    end

endmodule

// ----- hw/rtl/lsmt_timing_core.sv -----
// ----------------------------------------------------------------------------
// LCD scanline mode timer core
// Holds the line timing state and computes one result per tick.
// ----------------------------------------------------------------------------
module lsmt_timing_core #(
    parameter int LINE_CYCLES     = lsmt_pkg::DEF_LINE_CYCLES,
    parameter int OAM_CYCLES      = lsmt_pkg::DEF_OAM_CYCLES,
    parameter int TRANSFER_CYCLES = lsmt_pkg::DEF_TRANSFER_CYCLES,
    parameter int VISIBLE_LINES   = lsmt_pkg::DEF_VISIBLE_LINES,
    parameter int LAST_LINE       = lsmt_pkg::DEF_LAST_LINE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  lsmt_pkg::in_item_t  item,
    input  lsmt_pkg::cfg_t      cfg,
    output lsmt_pkg::out_item_t result
);
    import lsmt_pkg::*;

    localparam int CNT_W      = $clog2(LINE_CYCLES + 1);
    localparam int OAM_BOUND  = LINE_CYCLES - OAM_CYCLES;
    localparam int XFER_BOUND = OAM_BOUND - TRANSFER_CYCLES;

    // A bound at or below zero is always met by a positive countdown.
    localparam logic [CNT_W-1:0] OAM_BOUND_U  = CNT_W'((OAM_BOUND > 0) ? OAM_BOUND : 0);
    localparam logic [CNT_W-1:0] XFER_BOUND_U = CNT_W'((XFER_BOUND > 0) ? XFER_BOUND : 0);
    localparam logic [CNT_W-1:0] LINE_U       = CNT_W'(LINE_CYCLES);
    localparam logic [7:0]       VISIBLE_U    = 8'(VISIBLE_LINES);
    localparam logic [7:0]       LAST_U       = 8'(LAST_LINE);

    logic [CNT_W-1:0] countdown_reg, countdown_next;
    logic [7:0]       line_reg, line_next;
    logic [1:0]       mode_reg, mode_next;
    logic             coinc_reg, coinc_next;
    logic [7:0]       drawn_reg, drawn_next;

    logic [CNT_W:0]   diff;
    logic             underflow;
    logic             req;
    logic             line_match;

    // Countdown after subtracting this tick's cycles.
    assign diff      = {1'b0, countdown_reg} - {{(CNT_W - 5){1'b0}}, item.elapsed_cycles};
    assign underflow = diff[CNT_W] || (diff == '0);
    assign line_match = (line_reg == cfg.line_compare);

    // Mode classification, interrupt requests and state update.
    always_comb
    begin
        countdown_next = countdown_reg;
        line_next      = line_reg;
        mode_next      = mode_reg;
        coinc_next     = coinc_reg;
        drawn_next     = drawn_reg;
        req            = 1'b0;
        result         = '0;

        if (!item.lcd_on)
        begin
            countdown_next = LINE_U;
            line_next      = '0;
            mode_next      = MODE_HBLANK;
        end
        else
        begin
            if (line_reg >= VISIBLE_U)
            begin
                mode_next = MODE_VBLANK;
                req       = cfg.vblank_mode_irq_enable;
            end
            else if (countdown_reg >= OAM_BOUND_U)
            begin
                if (line_reg != drawn_reg)
                begin
                    result.draw_request = 1'b1;
                    result.draw_line    = drawn_reg;
                    drawn_next          = line_reg;
                end
                mode_next = MODE_OAM;
                req       = cfg.oam_irq_enable;
            end
            else if (countdown_reg >= XFER_BOUND_U)
            begin
                mode_next = MODE_TRANSFER;
            end
            else
            begin
                mode_next = MODE_HBLANK;
                req       = cfg.hblank_irq_enable;
            end

            result.stat_irq = (req && (mode_next != mode_reg))
                              || (line_match && cfg.lyc_irq_enable);
            coinc_next = line_match;

            if (underflow)
            begin
                line_next         = (line_reg >= LAST_U) ? 8'd0 : line_reg + 8'd1;
                countdown_next    = diff[CNT_W-1:0] + LINE_U;
                result.vblank_irq = (line_next == VISIBLE_U);
            end
            else
            begin
                countdown_next = diff[CNT_W-1:0];
            end
        end

        result.lcd_mode     = item.lcd_on ? mode_next : MODE_HBLANK;
        result.current_line = line_next;
        result.coincidence  = coinc_next;
    end

    // Timing state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= LINE_U;
            line_reg      <= '0;
            mode_reg      <= MODE_HBLANK;
            coinc_reg     <= 1'b0;
            drawn_reg     <= '0;
        end
        else if (update)
        begin
            countdown_reg <= countdown_next;
            line_reg      <= line_next;
            mode_reg      <= mode_next;
            coinc_reg     <= coinc_next;
            drawn_reg     <= drawn_next;
        end
    end

endmodule
